### src/hdtm_pkg.sv
// shared constants, codes and types of the header dynamic table manager
package hdtm_pkg;

  // table geometry; ENTRY_SLOTS must be a power of two (ring index wraps by truncation)
  localparam int TABLE_BYTES    = 4096;
  localparam int ENTRY_SLOTS    = 128;
  localparam int SLOT_W         = $clog2(ENTRY_SLOTS);
  localparam int CNT_W          = $clog2(ENTRY_SLOTS + 1);
  localparam int BYTES_W        = $clog2(TABLE_BYTES + 1);
  localparam int ENTRY_OVERHEAD = 32;
  localparam int LEN_W          = 16;
  localparam int COST_W         = LEN_W + 2;
  localparam int IDX_W          = 63;
  localparam int CFG_W          = 13;
  localparam int FULL_W         = CFG_W + 1;
  localparam int DIV_STEPS      = IDX_W + 1;
  localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

  // operation codes
  localparam logic [2:0] OP_INSERT     = 3'd0;
  localparam logic [2:0] OP_SET_CAP    = 3'd1;
  localparam logic [2:0] OP_LOOKUP_ABS = 3'd2;
  localparam logic [2:0] OP_LOOKUP_REL = 3'd3;
  localparam logic [2:0] OP_DECODE     = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_TOO_LARGE  = 3'd1;
  localparam logic [2:0] ST_NO_SLOT    = 3'd2;
  localparam logic [2:0] ST_OVER_LIMIT = 3'd3;
  localparam logic [2:0] ST_BAD_INDEX  = 3'd4;
  localparam logic [2:0] ST_EVICTED    = 3'd5;
  localparam logic [2:0] ST_BAD_PREFIX = 3'd6;

  // register indexes
  localparam logic REG_CAP_LIMIT   = 1'b0;
  localparam logic REG_MAX_ENTRIES = 1'b1;

  typedef struct packed {
    logic [2:0]       operation;
    logic [LEN_W-1:0] name_length;
    logic [LEN_W-1:0] value_length;
    logic [IDX_W-1:0] table_index;
    logic [IDX_W-1:0] new_capacity;
    logic [IDX_W-1:0] encoded_insert_count;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [LEN_W-1:0] out_name_length;
    logic [LEN_W-1:0] out_value_length;
    logic [6:0]       entry_slot;
    logic [IDX_W-1:0] absolute_index;
    logic [IDX_W-1:0] required_insert_count;
  } out_item_t;

  typedef enum logic [2:0] {
    KIND_DONE,
    KIND_INSERT,
    KIND_SETCAP,
    KIND_LOOKUP,
    KIND_DIVIDE
  } disp_kind_t;

  typedef struct packed {
    logic load;
    logic cfg_wr;
    logic dispatch;
    logic ev_rd;
    logic ev_apply;
    logic ev_end;
    logic ins_commit;
    logic div_step;
    logic dec_fin;
    logic look_fin;
  } dp_cmd_t;

  typedef struct packed {
    disp_kind_t kind;
    logic       evict_more;
    logic       div_last;
    logic       cfg_evict;
  } dp_sts_t;

endpackage

### src/hdtm_ram.sv
// generic single write port ram with registered read
module hdtm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/hdtm_ctrl.sv
// sequencing state machine of the header dynamic table manager
module hdtm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  output hdtm_pkg::dp_cmd_t cmd,
  input  hdtm_pkg::dp_sts_t sts
);
  import hdtm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_EV_CHK,
    S_EV_APPLY,
    S_INS,
    S_DIV,
    S_DEC_FIN,
    S_LOOK_FIN,
    S_OUT
  } state_t;

  typedef enum logic [1:0] {
    M_CFG,
    M_CAP,
    M_INS
  } mode_t;

  state_t state_r;
  mode_t  mode_r;

  assign cfg_ready = (state_r == S_IDLE);
  assign in_stall  = (state_r != S_IDLE) || cfg_valid;
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    cmd            = '0;
    cmd.cfg_wr     = (state_r == S_IDLE) && cfg_valid;
    cmd.load       = (state_r == S_IDLE) && in_valid && !cfg_valid;
    cmd.dispatch   = (state_r == S_DISPATCH);
    cmd.ev_rd      = (state_r == S_EV_CHK) && sts.evict_more;
    cmd.ev_end     = (state_r == S_EV_CHK) && !sts.evict_more;
    cmd.ev_apply   = (state_r == S_EV_APPLY);
    cmd.ins_commit = (state_r == S_INS);
    cmd.div_step   = (state_r == S_DIV);
    cmd.dec_fin    = (state_r == S_DEC_FIN);
    cmd.look_fin   = (state_r == S_LOOK_FIN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= M_CFG;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (cfg_valid) begin
            if (sts.cfg_evict) begin
              mode_r  <= M_CFG;
              state_r <= S_EV_CHK;
            end
          end else if (in_valid) begin
            state_r <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          case (sts.kind)
            KIND_INSERT: begin
              mode_r  <= M_INS;
              state_r <= S_EV_CHK;
            end
            KIND_SETCAP: begin
              mode_r  <= M_CAP;
              state_r <= S_EV_CHK;
            end
            KIND_LOOKUP: state_r <= S_LOOK_FIN;
            KIND_DIVIDE: state_r <= S_DIV;
            default:     state_r <= S_OUT;
          endcase
        end
        S_EV_CHK: begin
          if (sts.evict_more) begin
            state_r <= S_EV_APPLY;
          end else begin
            case (mode_r)
              M_CAP:   state_r <= S_OUT;
              M_INS:   state_r <= S_INS;
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_EV_APPLY: state_r <= S_EV_CHK;
        S_INS:      state_r <= S_OUT;
        S_DIV: begin
          if (sts.div_last) begin
            state_r <= S_DEC_FIN;
          end
        end
        S_DEC_FIN:  state_r <= S_OUT;
        S_LOOK_FIN: state_r <= S_OUT;
        S_OUT: begin
          if (!out_stall) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### src/hdtm_dp.sv
// table state, eviction walk, lookup, and insert count divider
module hdtm_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  hdtm_pkg::in_item_t        in_item,
  input  logic                      cfg_index,
  input  logic [hdtm_pkg::CFG_W-1:0] cfg_data,
  input  hdtm_pkg::dp_cmd_t         cmd,
  output hdtm_pkg::dp_sts_t         sts,
  output hdtm_pkg::out_item_t       out_item
);
  import hdtm_pkg::*;

  in_item_t            item_r;
  out_item_t           res_r;
  out_item_t           res_nxt;
  logic [BYTES_W-1:0]  cap_limit_r;
  logic [CFG_W-1:0]    max_entries_r;
  logic [BYTES_W-1:0]  cur_cap_r;
  logic [BYTES_W-1:0]  bytes_r;
  logic [CNT_W-1:0]    count_r;
  logic [SLOT_W-1:0]   newest_r;
  logic [IDX_W-1:0]    ins_tot_r;
  logic [IDX_W-1:0]    ev_tot_r;
  logic [BYTES_W-1:0]  want_r;
  logic [BYTES_W-1:0]  cost_r;
  logic [SLOT_W-1:0]   look_slot_r;
  logic [IDX_W:0]      maxv_r;
  logic [IDX_W:0]      dvd_r;
  logic [FULL_W-1:0]   rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;

  logic [BYTES_W-1:0]  cfg_lim_sat;
  logic                cfg_evict;
  logic [COST_W-1:0]   ins_cost;
  logic [IDX_W-1:0]    look_abs;
  logic [IDX_W-1:0]    back;
  logic [SLOT_W-1:0]   look_slot;
  logic [2:0]          look_status;
  logic [FULL_W-1:0]   full;
  logic [IDX_W:0]      maxv;
  disp_kind_t          kind;
  logic [2:0]          disp_status;
  logic [SLOT_W-1:0]   oldest;
  logic [SLOT_W-1:0]   ins_slot;
  logic                ins_ok;
  logic                evict_more;
  logic                ram_re;
  logic [SLOT_W-1:0]   ram_raddr;
  logic [2*LEN_W-1:0]  ram_rdata;
  logic [COST_W-1:0]   rd_cost;
  logic [FULL_W:0]     trial;
  logic [IDX_W:0]      wrap;
  logic [IDX_W+1:0]    ric;
  logic [IDX_W+1:0]    ric_adj;
  logic                ric_bad;

  // limit saturates to the table size
  assign cfg_lim_sat = (32'(cfg_data) > 32'(TABLE_BYTES)) ? BYTES_W'(TABLE_BYTES)
                                                          : BYTES_W'(cfg_data);
  assign cfg_evict = (cfg_index == REG_CAP_LIMIT) && (cfg_lim_sat < cur_cap_r);

  assign ins_cost = COST_W'(item_r.name_length) + COST_W'(item_r.value_length)
                  + COST_W'(ENTRY_OVERHEAD);

  assign look_abs  = (item_r.operation == OP_LOOKUP_REL)
                   ? (ins_tot_r - IDX_W'(1) - item_r.table_index) : item_r.table_index;
  assign back      = ins_tot_r - IDX_W'(1) - look_abs;
  assign look_slot = newest_r + back[SLOT_W-1:0];

  always_comb begin
    look_status = ST_OK;
    if ((item_r.operation == OP_LOOKUP_REL) && (item_r.table_index >= ins_tot_r)) begin
      look_status = ST_BAD_INDEX;
    end else if (look_abs >= ins_tot_r) begin
      look_status = ST_BAD_INDEX;
    end else if ((look_abs < ev_tot_r) || (back >= IDX_W'(count_r))) begin
      look_status = ST_EVICTED;
    end
  end

  assign full = {max_entries_r, 1'b0};
  assign maxv = {1'b0, ins_tot_r} + (IDX_W + 1)'(max_entries_r);

  always_comb begin
    kind        = KIND_DONE;
    disp_status = ST_OK;
    case (item_r.operation)
      OP_INSERT: begin
        if (ins_cost > COST_W'(cur_cap_r)) begin
          disp_status = ST_TOO_LARGE;
        end else begin
          kind = KIND_INSERT;
        end
      end
      OP_SET_CAP: begin
        if (item_r.new_capacity > IDX_W'(cap_limit_r)) begin
          disp_status = ST_OVER_LIMIT;
        end else begin
          kind = KIND_SETCAP;
        end
      end
      OP_LOOKUP_ABS, OP_LOOKUP_REL: begin
        if (look_status != ST_OK) begin
          disp_status = look_status;
        end else begin
          kind = KIND_LOOKUP;
        end
      end
      OP_DECODE: begin
        if (item_r.encoded_insert_count == '0) begin
          disp_status = ST_OK;
        end else if ((max_entries_r == '0) ||
                     (item_r.encoded_insert_count > IDX_W'(full))) begin
          disp_status = ST_BAD_PREFIX;
        end else begin
          kind = KIND_DIVIDE;
        end
      end
      default: disp_status = ST_OK;
    endcase
  end

  // eviction walk reads the oldest live slot
  assign oldest     = newest_r + SLOT_W'(count_r - CNT_W'(1));
  assign evict_more = (count_r != '0) && (bytes_r > want_r);
  assign ins_slot   = newest_r - SLOT_W'(1);
  assign ins_ok     = (count_r != CNT_W'(ENTRY_SLOTS));

  assign ram_re    = cmd.ev_rd || cmd.dispatch;
  assign ram_raddr = cmd.ev_rd ? oldest : look_slot;

  hdtm_ram #(
    .WIDTH (2 * LEN_W),
    .DEPTH (ENTRY_SLOTS)
  ) u_lengths (
    .clk   (clk),
    .we    (cmd.ins_commit && ins_ok),
    .waddr (ins_slot),
    .wdata ({item_r.name_length, item_r.value_length}),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_cost = COST_W'(ram_rdata[2*LEN_W-1:LEN_W]) + COST_W'(ram_rdata[LEN_W-1:0])
                 + COST_W'(ENTRY_OVERHEAD);

  // restoring remainder step, one dividend bit a cycle
  assign trial = {rem_r, dvd_r[IDX_W]};

  // wrap = maxv - maxv mod full
  assign wrap    = maxv_r - (IDX_W + 1)'(rem_r);
  assign ric     = {1'b0, wrap} + (IDX_W + 2)'(item_r.encoded_insert_count) - (IDX_W + 2)'(1);
  always_comb begin
    ric_adj = ric;
    ric_bad = 1'b0;
    if (ric > {1'b0, maxv_r}) begin
      if (ric <= (IDX_W + 2)'(full)) begin
        ric_bad = 1'b1;
      end else begin
        ric_adj = ric - (IDX_W + 2)'(full);
      end
    end
    if (ric_adj == '0) begin
      ric_bad = 1'b1;
    end
  end

  // result register next value
  always_comb begin
    res_nxt = res_r;
    if (cmd.dispatch) begin
      res_nxt        = '0;
      res_nxt.status = disp_status;
      if (kind == KIND_LOOKUP) begin
        res_nxt.absolute_index = look_abs;
      end
    end
    if (cmd.ins_commit) begin
      if (ins_ok) begin
        res_nxt.entry_slot     = 7'(ins_slot);
        res_nxt.absolute_index = ins_tot_r;
      end else begin
        res_nxt.status = ST_NO_SLOT;
      end
    end
    if (cmd.look_fin) begin
      res_nxt.out_name_length  = ram_rdata[2*LEN_W-1:LEN_W];
      res_nxt.out_value_length = ram_rdata[LEN_W-1:0];
      res_nxt.entry_slot       = 7'(look_slot_r);
    end
    if (cmd.dec_fin) begin
      if (ric_bad) begin
        res_nxt.status = ST_BAD_PREFIX;
      end else begin
        res_nxt.required_insert_count = ric_adj[IDX_W-1:0];
      end
    end
  end

  assign sts.kind       = kind;
  assign sts.evict_more = evict_more;
  assign sts.div_last   = (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
  assign sts.cfg_evict  = cfg_evict;
  assign out_item       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_limit_r   <= (TABLE_BYTES < 4096) ? BYTES_W'(TABLE_BYTES) : BYTES_W'(4096);
      max_entries_r <= CFG_W'(128);
      cur_cap_r     <= '0;
      bytes_r       <= '0;
      count_r       <= '0;
      newest_r      <= '0;
      ins_tot_r     <= '0;
      ev_tot_r      <= '0;
    end else begin
      if (cmd.cfg_wr) begin
        if (cfg_index == REG_CAP_LIMIT) begin
          cap_limit_r <= cfg_lim_sat;
          if (cfg_evict) begin
            cur_cap_r <= cfg_lim_sat;
          end
        end else begin
          max_entries_r <= cfg_data;
        end
      end
      if (cmd.dispatch && (kind == KIND_SETCAP)) begin
        cur_cap_r <= BYTES_W'(item_r.new_capacity);
      end
      if (cmd.ev_apply) begin
        bytes_r  <= (rd_cost > COST_W'(bytes_r)) ? '0 : bytes_r - BYTES_W'(rd_cost);
        count_r  <= count_r - CNT_W'(1);
        ev_tot_r <= ev_tot_r + IDX_W'(1);
      end
      if (cmd.ev_end && (count_r == '0)) begin
        bytes_r <= '0;
      end
      if (cmd.ins_commit && ins_ok) begin
        newest_r  <= ins_slot;
        count_r   <= count_r + CNT_W'(1);
        bytes_r   <= bytes_r + cost_r;
        ins_tot_r <= ins_tot_r + IDX_W'(1);
      end
    end
  end

  // item, result and scratch registers
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (cmd.cfg_wr && cfg_evict) begin
      want_r <= cfg_lim_sat;
    end
    if (cmd.dispatch) begin
      case (kind)
        KIND_INSERT: begin
          want_r <= cur_cap_r - BYTES_W'(ins_cost);
          cost_r <= BYTES_W'(ins_cost);
        end
        KIND_SETCAP: want_r <= BYTES_W'(item_r.new_capacity);
        KIND_LOOKUP: look_slot_r <= look_slot;
        KIND_DIVIDE: begin
          maxv_r    <= maxv;
          dvd_r     <= maxv;
          rem_r     <= '0;
          div_cnt_r <= '0;
        end
        default: ;
      endcase
    end
    if (cmd.div_step) begin
      rem_r     <= (trial >= (FULL_W + 1)'(full)) ? FULL_W'(trial - (FULL_W + 1)'(full))
                                                 : FULL_W'(trial);
      dvd_r     <= {dvd_r[IDX_W-1:0], 1'b0};
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ENTRY_SLOTS))
    else $error("entry count beyond ring size");

  a_cap_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cur_cap_r <= cap_limit_r)
    else $error("capacity above limit");

  a_evict_dec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ev_apply |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("eviction did not drop one entry");

endmodule

### src/header_dynamic_table_manager.sv
// top level of the header dynamic table manager
// one item at a time, next taken in the idle state after the result is accepted; lookup:
// dispatch, lookup finish, out; early errors, unused codes: dispatch, out; set capacity:
// dispatch, eviction walk, out; insert: dispatch, eviction walk, commit, out; decode:
// dispatch, 64-step remainder loop, decode finish, out; evictions read the length memory
// synchronous active-low reset empties the table, capacity 0, limit 4096, max_entries 128
module header_dynamic_table_manager (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  hdtm_pkg::in_item_t         in_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output hdtm_pkg::out_item_t        out_item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [hdtm_pkg::CFG_W-1:0] cfg_data
);
  import hdtm_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: accepts items and register writes only when idle
  hdtm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath: counters, ring of entry lengths, divider, result register
  hdtm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_item)
  );

endmodule

### verif/tb.sv
// self-checking testbench for the header dynamic table manager
`timescale 1ns / 1ps

module tb;
  import hdtm_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_index = REG_CAP_LIMIT;
  logic [CFG_W-1:0] cfg_data = '0;

  header_dynamic_table_manager u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // table shadow: lengths packed name in upper half, value in lower half
  logic [31:0]      tbl_len [ENTRY_SLOTS];
  logic [SLOT_W-1:0] tbl_newest;
  int unsigned      tbl_count;
  int unsigned      tbl_bytes;
  int unsigned      tbl_cap;
  logic [IDX_W-1:0] tbl_inserts;
  logic [IDX_W-1:0] tbl_evicts;
  int unsigned      lim_bytes;
  int unsigned      lim_entries;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int        error_count = 0;

  // sender and receiver pacing knobs, set per phase
  int        stall_pct = 0;
  int        cur_phase = -1;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  longint    cycle_count = 0;

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // drop oldest entries until bytes in use fit the target
  function automatic void shrink_to(input int unsigned target);
    int unsigned oldest;
    int unsigned cost;
    while (tbl_count != 0 && tbl_bytes > target) begin
      oldest = (tbl_newest + tbl_count - 1) % ENTRY_SLOTS;
      cost = tbl_len[oldest][31:16] + tbl_len[oldest][15:0] + ENTRY_OVERHEAD;
      tbl_bytes = (cost > tbl_bytes) ? 0 : tbl_bytes - cost;
      tbl_count--;
      tbl_evicts = tbl_evicts + 1'b1;
    end
    if (tbl_count == 0) tbl_bytes = 0;
  endfunction

  function automatic logic [2:0] fetch_entry(input logic [IDX_W-1:0] abs_idx,
                                             inout out_item_t res);
    logic [IDX_W-1:0] back;
    int unsigned slot;
    if (abs_idx >= tbl_inserts) return ST_BAD_INDEX;
    if (abs_idx < tbl_evicts) return ST_EVICTED;
    back = tbl_inserts - 1'b1 - abs_idx;
    if (back >= tbl_count) return ST_EVICTED;
    slot = 32'((tbl_newest + back) % ENTRY_SLOTS);
    res.out_name_length  = tbl_len[slot][31:16];
    res.out_value_length = tbl_len[slot][15:0];
    res.entry_slot       = slot[6:0];
    res.absolute_index   = abs_idx;
    return ST_OK;
  endfunction

  function automatic logic [2:0] decode_ric(input logic [IDX_W-1:0] enc63,
                                            inout out_item_t res);
    longint unsigned enc, full, maxv, wrap, ric;
    enc = 64'(enc63);
    if (enc == 0) return ST_OK;
    if (lim_entries == 0) return ST_BAD_PREFIX;
    full = 2 * lim_entries;
    if (enc > full) return ST_BAD_PREFIX;
    maxv = longint'(tbl_inserts) + lim_entries;
    wrap = (maxv / full) * full;
    ric = wrap + enc - 1;
    if (ric > maxv) begin
      if (ric <= full) return ST_BAD_PREFIX;
      ric -= full;
    end
    if (ric == 0) return ST_BAD_PREFIX;
    res.required_insert_count = ric[IDX_W-1:0];
    return ST_OK;
  endfunction

  // expected result of one accepted item; updates the table shadow
  function automatic out_item_t table_result(input in_item_t it);
    out_item_t res;
    logic [2:0] st;
    int unsigned cost;
    res = '0;
    st = ST_OK;
    case (it.operation)
      OP_INSERT: begin
        cost = it.name_length + it.value_length + ENTRY_OVERHEAD;
        if (cost > tbl_cap) st = ST_TOO_LARGE;
        else begin
          shrink_to(tbl_cap - cost);
          if (tbl_count + 1 > ENTRY_SLOTS) st = ST_NO_SLOT;
          else begin
            tbl_newest = tbl_newest - 1'b1;
            tbl_len[tbl_newest] = {it.name_length, it.value_length};
            tbl_count++;
            tbl_bytes += cost;
            res.entry_slot = 7'(tbl_newest);
            res.absolute_index = tbl_inserts;
            tbl_inserts = tbl_inserts + 1'b1;
          end
        end
      end
      OP_SET_CAP: begin
        if (it.new_capacity > lim_bytes) st = ST_OVER_LIMIT;
        else begin
          tbl_cap = 32'(it.new_capacity);
          shrink_to(tbl_cap);
        end
      end
      OP_LOOKUP_ABS: st = fetch_entry(it.table_index, res);
      OP_LOOKUP_REL: begin
        if (it.table_index >= tbl_inserts) st = ST_BAD_INDEX;
        else st = fetch_entry(tbl_inserts - 1'b1 - it.table_index, res);
      end
      OP_DECODE: st = decode_ric(it.encoded_insert_count, res);
      default: ;
    endcase
    if (st != ST_OK) res = '0;
    res.status = st;
    return res;
  endfunction

  function automatic void apply_reg(input logic idx, input logic [CFG_W-1:0] val);
    if (idx == REG_CAP_LIMIT) begin
      lim_bytes = (val > TABLE_BYTES) ? TABLE_BYTES : 32'(val);
      if (tbl_cap > lim_bytes) begin
        tbl_cap = lim_bytes;
        shrink_to(tbl_cap);
      end
    end else begin
      lim_entries = 32'(val);
    end
  endfunction

  // driver: bursts of items with random gaps, payload held while stalled
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) expected_results.push_back(table_result(in_item));
      if (in_valid && in_stall) begin
        // hold the offered item
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_item <= pending_items.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 30);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, with one long hold-off in phase 2
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (cur_phase == 2 && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= 400;
      hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    out_item_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report("result with nothing expected");
      end else begin
        exp_res = expected_results.pop_front();
        if (out_item.status !== exp_res.status)
          report($sformatf("status %0d, expected %0d", out_item.status, exp_res.status));
        if (out_item.out_name_length !== exp_res.out_name_length)
          report($sformatf("name length %0d, expected %0d",
                           out_item.out_name_length, exp_res.out_name_length));
        if (out_item.out_value_length !== exp_res.out_value_length)
          report($sformatf("value length %0d, expected %0d",
                           out_item.out_value_length, exp_res.out_value_length));
        if (out_item.entry_slot !== exp_res.entry_slot)
          report($sformatf("slot %0d, expected %0d",
                           out_item.entry_slot, exp_res.entry_slot));
        if (out_item.absolute_index !== exp_res.absolute_index)
          report($sformatf("absolute index %0d, expected %0d",
                           out_item.absolute_index, exp_res.absolute_index));
        if (out_item.required_insert_count !== exp_res.required_insert_count)
          report($sformatf("insert count %0d, expected %0d",
                           out_item.required_insert_count, exp_res.required_insert_count));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 5000000) begin
      $display("header_dynamic_table_manager regression: fail");
      $finish;
    end
  end

  function automatic in_item_t make_item(input logic [2:0] op,
                                         input logic [LEN_W-1:0] nl, vl,
                                         input logic [IDX_W-1:0] idx, cap, enc);
    in_item_t it;
    it.operation = op;
    it.name_length = nl;
    it.value_length = vl;
    it.table_index = idx;
    it.new_capacity = cap;
    it.encoded_insert_count = enc;
    return it;
  endfunction

  // inserts queued so far, used to aim lookups near live entries
  longint queued_inserts = 0;

  function automatic in_item_t random_item();
    in_item_t it;
    int pick;
    it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    pick = $urandom_range(0, 99);
    if (pick < 38) begin
      it.operation = OP_INSERT;
      if ($urandom_range(0, 19) != 0) begin
        it.name_length = LEN_W'($urandom_range(0, 120));
        it.value_length = ($urandom_range(0, 3) == 0) ? LEN_W'($urandom_range(0, 1500))
                                                       : LEN_W'($urandom_range(0, 100));
      end
      queued_inserts++;
    end else if (pick < 48) begin
      it.operation = OP_SET_CAP;
      if ($urandom_range(0, 7) != 0) it.new_capacity = IDX_W'($urandom_range(0, 4200));
    end else if (pick < 68) begin
      it.operation = OP_LOOKUP_ABS;
      if ($urandom_range(0, 9) != 0)
        it.table_index = (queued_inserts > 40) ?
                         IDX_W'(queued_inserts - $urandom_range(0, 50))
                         : IDX_W'($urandom_range(0, 45));
    end else if (pick < 86) begin
      it.operation = OP_LOOKUP_REL;
      if ($urandom_range(0, 9) != 0) it.table_index = IDX_W'($urandom_range(0, 60));
    end else if (pick < 96) begin
      it.operation = OP_DECODE;
      if ($urandom_range(0, 7) != 0)
        it.encoded_insert_count = IDX_W'($urandom_range(0, 2 * lim_entries + 2));
    end else begin
      it.operation = 3'($urandom_range(5, 7));
    end
    return it;
  endfunction

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    // let the block settle
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  localparam logic [IDX_W-1:0] ALL_ONES = '1;

  initial begin
    logic [CFG_W-1:0] limits [8];
    logic [CFG_W-1:0] entries [8];
    tbl_newest = '0;
    tbl_count = 0;
    tbl_bytes = 0;
    tbl_cap = 0;
    tbl_inserts = '0;
    tbl_evicts = '0;
    lim_bytes = TABLE_BYTES;
    lim_entries = 128;
    foreach (tbl_len[i]) tbl_len[i] = '0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every operation, each error case but running out of slots
    pending_items.push_back(make_item(OP_INSERT, 0, 0, 0, 0, 0));          // no capacity yet
    pending_items.push_back(make_item(OP_DECODE, 0, 0, 0, 0, 0));          // encoded zero
    pending_items.push_back(make_item(OP_DECODE, 0, 0, 0, 0, 1));          // result zero
    pending_items.push_back(make_item(OP_SET_CAP, 0, 0, 0, ALL_ONES, 0));  // over limit
    pending_items.push_back(make_item(OP_SET_CAP, 0, 0, 0, 4096, 0));
    pending_items.push_back(make_item(OP_INSERT, 16'hFFFF, 16'hFFFF, 0, 0, 0));
    pending_items.push_back(make_item(OP_INSERT, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_INSERT, 2000, 2000, 0, 0, 0));    // fills the table to 4064 bytes
    pending_items.push_back(make_item(OP_INSERT, 16'hAAAA, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_LOOKUP_ABS, 0, 0, 0, 0, 0));      // oldest entry, still live
    pending_items.push_back(make_item(OP_LOOKUP_ABS, 0, 0, 1, 0, 0));
    pending_items.push_back(make_item(OP_LOOKUP_ABS, 0, 0, ALL_ONES, 0, 0));
    pending_items.push_back(make_item(OP_LOOKUP_REL, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_LOOKUP_REL, 0, 0, ALL_ONES, 0, 0));
    pending_items.push_back(make_item(OP_DECODE, 0, 0, 0, 0, 2));
    pending_items.push_back(make_item(OP_DECODE, 0, 0, 0, 0, 256));
    pending_items.push_back(make_item(OP_DECODE, 0, 0, 0, 0, 257));
    pending_items.push_back(make_item(OP_DECODE, 0, 0, 0, 0, ALL_ONES));
    pending_items.push_back(make_item(3'd5, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(3'd6, 16'hFFFF, 16'hFFFF, ALL_ONES, ALL_ONES, ALL_ONES));
    pending_items.push_back(make_item(3'd7, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_SET_CAP, 0, 0, 0, 0, 0));         // evicts all
    pending_items.push_back(make_item(OP_LOOKUP_REL, 0, 0, 0, 0, 0));
    pending_items.push_back(make_item(OP_SET_CAP, 0, 0, 0, 4096, 0));
    queued_inserts = 4;
    wait_idle();

    // register settings per phase, extremes included
    limits  = '{13'd4096, 13'd0, 13'd8191, 13'd1000, 13'd4096, 13'd64, 13'd3000, 13'd4095};
    entries = '{13'd128, 13'd0, 13'd8191, 13'd1, 13'd2, 13'd4096, 13'd100, 13'd128};
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_CAP_LIMIT, (ph == 6) ? 13'($urandom_range(0, 8191)) : limits[ph]);
      write_reg(REG_MAX_ENTRIES, (ph == 6) ? 13'($urandom_range(0, 8191)) : entries[ph]);
      // phase 0 and 4 run with no receiver stalls
      stall_pct = (ph == 0 || ph == 4) ? 0 : $urandom_range(10, 60);
      // a fresh capacity so that inserts land
      pending_items.push_back(make_item(OP_SET_CAP, 0, 0, 0,
                                        IDX_W'($urandom_range(0, lim_bytes)), 0));
      for (int k = 0; k < 228; k++) pending_items.push_back(random_item());
      // phase 2 gets a long receiver hold-off while the sender keeps offering items
      cur_phase = ph;
      wait_idle();
    end

    if (error_count == 0) begin
      $display("header_dynamic_table_manager regression: pass");
    end else begin
      $display("header_dynamic_table_manager regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
src/hdtm_pkg.sv
src/hdtm_ram.sv
src/hdtm_ctrl.sv
src/hdtm_dp.sv
src/header_dynamic_table_manager.sv
verif/tb.sv
